[rtl/gdad_pkg.sv]
// Shared types, calendar constants and month length tables for the date adder.
package gdad_pkg;

  localparam int unsigned DAY_W    = 5;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned YEAR_W   = 14;
  localparam int unsigned COUNT_W  = 20;
  // The offset holds a day of year plus the full day count.
  localparam int unsigned OFF_W    = 21;
  // The working year can run past the output field before it wraps.
  localparam int unsigned WYEAR_W  = 15;
  localparam int unsigned YMOD_W   = 14;

  localparam logic [8:0]  DAYS_LEAP   = 9'd366;
  localparam logic [8:0]  DAYS_COMMON = 9'd365;
  localparam logic [4:0]  FEB_LEAP    = 5'd29;
  localparam logic [8:0]  CYCLE_YEARS = 9'd400;
  localparam logic [8:0]  CENTURY     = 9'd100;
  localparam logic [3:0]  JANUARY     = 4'd1;
  localparam logic [3:0]  FEBRUARY    = 4'd2;
  localparam logic [3:0]  DECEMBER    = 4'd12;

  typedef struct packed {
    logic [DAY_W-1:0]   start_day;
    logic [MONTH_W-1:0] start_month;
    logic [YEAR_W-1:0]  start_year;
    logic [COUNT_W-1:0] days_to_add;
  } date_in_t;

  typedef struct packed {
    logic [DAY_W-1:0]   result_day;
    logic [MONTH_W-1:0] result_month;
    logic [YEAR_W-1:0]  result_year;
  } date_out_t;

  // Leap rule from the year's position in the 400 year cycle.
  function automatic logic is_leap(input logic [8:0] ycyc);
    logic century;
    century = (ycyc == CENTURY) || (ycyc == 9'(2 * CENTURY)) ||
              (ycyc == 9'(3 * CENTURY));
    return (ycyc[1:0] == 2'b00) && !century;
  endfunction

  function automatic logic [8:0] year_len(input logic leap);
    return leap ? DAYS_LEAP : DAYS_COMMON;
  endfunction

  // Month is expected in 1..12; other codes fall to 31 days.
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd2:                    len = leap ? FEB_LEAP : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      default:                 len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

[rtl/gregorian_date_add_days_core.sv]
// Gregorian date plus day count: sequencer around one shared add/subtract unit.
//
//   channel  | ports                  | dir | handshake
//   ---------+------------------------+-----+--------------------------------
//   request  | start, busy, arg       | in  | beat taken when start & !busy
//   result   | done, result           | out | one cycle strobe, no back-pressure
//
// The one adder/subtractor does one step at a time: a 400 year reduction,
// one month sum, the day count sum, or one year or month subtraction.
// Reset (rst, synchronous) returns the sequencer to idle and drops done.
// The receiver cannot stall; busy stays high from the accepted beat until
// the cycle in which done is raised.
module gregorian_date_add_days_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  gdad_pkg::date_in_t   arg,
  output logic                 done,
  output gdad_pkg::date_out_t  result
);

  typedef enum logic [2:0] {
    S_IDLE, S_MOD, S_DAY, S_SUMM, S_YSUM, S_YEAR, S_MONTH
  } state_t;

  state_t state;

  logic [gdad_pkg::DAY_W-1:0]   day;
  logic [gdad_pkg::MONTH_W-1:0] mon;
  logic [gdad_pkg::MONTH_W-1:0] m;
  logic [gdad_pkg::WYEAR_W-1:0] year;
  logic [gdad_pkg::YMOD_W-1:0]  ymod;
  logic [gdad_pkg::COUNT_W-1:0] add;
  logic [gdad_pkg::OFF_W-1:0]   off;

  logic                         leap;
  logic [4:0]                   mlen_cur;
  logic [4:0]                   mlen_start;
  logic [8:0]                   ylen;
  logic [gdad_pkg::MONTH_W-1:0] mon_clamp;
  logic [gdad_pkg::DAY_W-1:0]   day_clamp;
  logic [gdad_pkg::YMOD_W-1:0]  ymod_inc;

  logic [gdad_pkg::OFF_W-1:0]   alu_a;
  logic [gdad_pkg::OFF_W-1:0]   alu_b;
  logic                         alu_sub;
  logic [gdad_pkg::OFF_W:0]     alu_res;
  logic                         alu_borrow;
  logic                         alu_gt;

  assign leap       = gdad_pkg::is_leap(ymod[8:0]);
  assign mlen_cur   = gdad_pkg::month_len(m, leap);
  assign mlen_start = gdad_pkg::month_len(mon, leap);
  assign ylen       = gdad_pkg::year_len(leap);

  always_comb begin
    if (arg.start_month == '0) begin
      mon_clamp = gdad_pkg::JANUARY;
    end else if (arg.start_month > gdad_pkg::DECEMBER) begin
      mon_clamp = gdad_pkg::DECEMBER;
    end else begin
      mon_clamp = arg.start_month;
    end
  end

  always_comb begin
    if (day == '0) begin
      day_clamp = gdad_pkg::DAY_W'(1);
    end else if (day > mlen_start) begin
      day_clamp = mlen_start;
    end else begin
      day_clamp = day;
    end
  end

  assign ymod_inc = (ymod[8:0] == gdad_pkg::CYCLE_YEARS - 9'd1) ? '0 : ymod + 1'b1;

  // The shared unit: operands are steered by the sequencer state.
  always_comb begin
    alu_a   = off;
    alu_b   = '0;
    alu_sub = 1'b0;
    unique case (state)
      S_MOD: begin
        alu_a   = gdad_pkg::OFF_W'(ymod);
        alu_b   = gdad_pkg::OFF_W'(gdad_pkg::CYCLE_YEARS);
        alu_sub = 1'b1;
      end
      S_SUMM: begin
        alu_b = gdad_pkg::OFF_W'(mlen_cur);
      end
      S_YSUM: begin
        alu_b = gdad_pkg::OFF_W'(add);
      end
      S_YEAR: begin
        alu_b   = gdad_pkg::OFF_W'(ylen);
        alu_sub = 1'b1;
      end
      S_MONTH: begin
        alu_b   = gdad_pkg::OFF_W'(mlen_cur);
        alu_sub = 1'b1;
      end
      default: begin
        alu_b = '0;
      end
    endcase
  end

  assign alu_res    = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b})
                              : ({1'b0, alu_a} + {1'b0, alu_b});
  assign alu_borrow = alu_res[gdad_pkg::OFF_W];
  assign alu_gt     = !alu_borrow && (alu_res[gdad_pkg::OFF_W-1:0] != '0);

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            day   <= arg.start_day;
            mon   <= mon_clamp;
            year  <= gdad_pkg::WYEAR_W'(arg.start_year);
            ymod  <= arg.start_year;
            add   <= arg.days_to_add;
            state <= S_MOD;
          end
        end
        S_MOD: begin
          if (!alu_borrow) begin
            ymod <= alu_res[gdad_pkg::YMOD_W-1:0];
          end else begin
            state <= S_DAY;
          end
        end
        S_DAY: begin
          off   <= gdad_pkg::OFF_W'(day_clamp);
          m     <= gdad_pkg::JANUARY;
          state <= S_SUMM;
        end
        S_SUMM: begin
          if (m < mon) begin
            off <= alu_res[gdad_pkg::OFF_W-1:0];
            m   <= m + 1'b1;
          end else begin
            state <= S_YSUM;
          end
        end
        S_YSUM: begin
          off   <= alu_res[gdad_pkg::OFF_W-1:0];
          state <= S_YEAR;
        end
        S_YEAR: begin
          // Peel whole years off while the offset runs past the year end.
          if (alu_gt) begin
            off  <= alu_res[gdad_pkg::OFF_W-1:0];
            year <= year + 1'b1;
            ymod <= ymod_inc;
          end else begin
            m     <= gdad_pkg::JANUARY;
            state <= S_MONTH;
          end
        end
        S_MONTH: begin
          if ((m < gdad_pkg::DECEMBER) && alu_gt) begin
            off <= alu_res[gdad_pkg::OFF_W-1:0];
            m   <= m + 1'b1;
          end else begin
            result.result_day   <= off[gdad_pkg::DAY_W-1:0];
            result.result_month <= m;
            result.result_year  <= year[gdad_pkg::YEAR_W-1:0];
            done                <= 1'b1;
            state               <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted beat did not make the block busy");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while the sequencer is still working");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe lasted more than one cycle");

  a_cycle_reduced: assert property (@(posedge clk) disable iff (rst)
    (state == S_YEAR || state == S_MONTH || state == S_SUMM) |->
      (ymod < gdad_pkg::YMOD_W'(gdad_pkg::CYCLE_YEARS)))
    else $error("year position left the 400 year cycle");

  a_result_month: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.result_month >= gdad_pkg::JANUARY) &&
             (result.result_month <= gdad_pkg::DECEMBER) &&
             (result.result_day != '0))
    else $error("result date out of calendar range");

endmodule

[tb/sv/gregorian_date_add_days_core_test.sv]
// Self-checking testbench for the Gregorian date plus day count core.
module gregorian_date_add_days_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STALL_LIMIT  = 20000;
  localparam int unsigned SETTLE_CYCLES = 64;
  localparam int unsigned RANDOM_ITEMS = 200;

  typedef struct {
    gdad_pkg::date_in_t  arg;
    gdad_pkg::date_out_t want;
  } pending_date_t;

  logic                clk;
  logic                rst   = 1'b1;
  logic                start = 1'b0;
  logic                busy;
  gdad_pkg::date_in_t  arg   = '0;
  logic                done;
  gdad_pkg::date_out_t result;

  pending_date_t pending_dates[$];
  int unsigned   error_count  = 0;
  int unsigned   quiet_cycles = 0;

  gregorian_date_add_days_core dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .arg    (arg),
    .done   (done),
    .result (result)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic bit is_leap_year(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned days_in_year(input int unsigned y);
    return is_leap_year(y) ? 366 : 365;
  endfunction

  function automatic int unsigned days_in_month(input int unsigned m, input int unsigned y);
    int unsigned len;
    case (m)
      2:             len = is_leap_year(y) ? 29 : 28;
      4, 6, 9, 11:   len = 30;
      default:       len = 31;
    endcase
    return len;
  endfunction

  // Expected date after the start date is clamped into the calendar.
  function automatic gdad_pkg::date_out_t advance_date(input gdad_pkg::date_in_t a);
    int unsigned         d, m, y, n, off, left, k;
    gdad_pkg::date_out_t r;
    d = a.start_day;
    m = a.start_month;
    y = a.start_year;
    n = a.days_to_add;
    if (m < gdad_pkg::JANUARY) m = gdad_pkg::JANUARY;
    if (m > gdad_pkg::DECEMBER) m = gdad_pkg::DECEMBER;
    if (d < 1) d = 1;
    if (d > days_in_month(m, y)) d = days_in_month(m, y);
    off = d;
    for (k = 1; k < m; k++) off += days_in_month(k, y);
    left = days_in_year(y) - off;
    if (n <= left) begin
      off += n;
    end else begin
      n -= left;
      y++;
      while (n > days_in_year(y)) begin
        n -= days_in_year(y);
        y++;
      end
      off = n;
    end
    m = gdad_pkg::JANUARY;
    while (m < gdad_pkg::DECEMBER && off > days_in_month(m, y)) begin
      off -= days_in_month(m, y);
      m++;
    end
    r.result_day   = gdad_pkg::DAY_W'(off);
    r.result_month = gdad_pkg::MONTH_W'(m);
    r.result_year  = gdad_pkg::YEAR_W'(y);
    return r;
  endfunction

  // Drive one beat and hold start until the core takes it.
  task automatic send_date(input int unsigned d, input int unsigned m,
                           input int unsigned y, input int unsigned n);
    gdad_pkg::date_in_t a;
    a.start_day   = gdad_pkg::DAY_W'(d);
    a.start_month = gdad_pkg::MONTH_W'(m);
    a.start_year  = gdad_pkg::YEAR_W'(y);
    a.days_to_add = gdad_pkg::COUNT_W'(n);
    arg   <= a;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    pending_dates.push_back('{a, advance_date(a)});
  endtask

  task automatic send_random_date();
    int unsigned d, m, y, n, pick;
    pick = $urandom_range(0, 9);
    if (pick < 8) begin
      m = $urandom_range(1, 12);
      y = $urandom_range(0, 9999);
      d = $urandom_range(1, days_in_month(m, y));
    end else begin
      m = $urandom_range(0, 15);
      y = $urandom_range(0, 16383);
      d = $urandom_range(0, 31);
    end
    if ($urandom_range(0, 3) == 0) y = $urandom_range(0, 16383);
    // Long day counts walk thousands of years, so keep most of them short.
    pick = $urandom_range(0, 7);
    if (pick == 0)      n = $urandom_range(0, 20'hFFFFF);
    else if (pick < 4)  n = $urandom_range(0, 3000);
    else                n = $urandom_range(0, 400000);
    send_date(d, m, y, n);
  endtask

  task automatic hold_sender(input int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic wait_all_results();
    start <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed_cases();
    send_date(1, gdad_pkg::JANUARY, 0, 0);
    send_date(31, gdad_pkg::DECEMBER, 9999, 20'hFFFFF);
    send_date(31, 15, 16383, 20'hFFFFF);
    send_date(0, 0, 2023, 0);
    send_date(31, gdad_pkg::FEBRUARY, 2023, 0);
    send_date(31, gdad_pkg::FEBRUARY, 2024, 0);
    send_date(30, gdad_pkg::FEBRUARY, 1900, 0);
    send_date(30, gdad_pkg::FEBRUARY, 2000, 0);
    send_date(15, 13, 2021, 10);
    // Remainders that land on or just past the last day of a year.
    send_date(1, gdad_pkg::JANUARY, 2023, 364);
    send_date(1, gdad_pkg::JANUARY, 2024, 365);
    send_date(1, 3, 2023, 305);
    send_date(1, gdad_pkg::JANUARY, 2023, 730);
    send_date(1, 3, 2023, 306);
    send_date(31, gdad_pkg::DECEMBER, 2023, 1);
    send_date(28, gdad_pkg::FEBRUARY, 2100, 1);
    send_date(28, gdad_pkg::FEBRUARY, 2400, 1);
    send_date(31, gdad_pkg::JANUARY, 2000, 29);
    send_date(15, 6, 9999, 0);
    send_date(1, gdad_pkg::JANUARY, 0, 20'hFFFFF);
    send_date(31, gdad_pkg::DECEMBER, 16383, 1);
    send_date(31, gdad_pkg::DECEMBER, 16383, 0);
  endtask

  task automatic test_random_bursts(input int unsigned count);
    int unsigned sent, burst, gap;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 8);
      repeat (burst) begin
        if (sent < count) begin
          send_random_date();
          sent++;
        end
      end
      if ($urandom_range(0, 3) == 0) gap = $urandom_range(40, 600);
      else gap = $urandom_range(0, 12);
      if (gap != 0) hold_sender(gap);
    end
  endtask

  task automatic test_back_to_back(input int unsigned count);
    repeat (count) send_random_date();
  endtask

  task automatic test_pause_until_drained();
    wait_all_results();
    test_back_to_back(4);
  endtask

  // Each done strobe carries one beat; compare it with the oldest prediction.
  always @(posedge clk) begin
    pending_date_t head;
    if (!rst && done) begin
      if (pending_dates.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("unexpected result %0d-%0d-%0d", result.result_year,
                   result.result_month, result.result_day);
      end else begin
        head = pending_dates.pop_front();
        if (result.result_day !== head.want.result_day ||
            result.result_month !== head.want.result_month ||
            result.result_year !== head.want.result_year) begin
          error_count++;
          if (error_count <= 10)
            $display("%0d-%0d-%0d + %0d: expected %0d-%0d-%0d, got %0d-%0d-%0d",
                     head.arg.start_year, head.arg.start_month, head.arg.start_day,
                     head.arg.days_to_add, head.want.result_year,
                     head.want.result_month, head.want.result_day,
                     result.result_year, result.result_month, result.result_day);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("gregorian_date_add_days_core_test: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_random_bursts(RANDOM_ITEMS / 2);
    test_pause_until_drained();
    test_back_to_back(16);
    test_random_bursts(RANDOM_ITEMS / 2 - 20);
    wait_all_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_dates.size() == 0) begin
      $display("gregorian_date_add_days_core_test: clean");
    end else begin
      $display("gregorian_date_add_days_core_test: errors");
    end
    $finish;
  end

endmodule
